[rtl/core/rlel_pkg.sv]
`timescale 1ns / 1ps

package rlel_pkg;

    // Literal group capacity and the widths that follow from it
    localparam int MAX_LITERAL = 32;
    localparam int LIT_IDX_W   = $clog2(MAX_LITERAL);
    localparam int LIT_LEN_W   = $clog2(MAX_LITERAL + 1);

    typedef logic [LIT_IDX_W-1:0] lit_idx_t;
    typedef logic [LIT_LEN_W-1:0] lit_len_t;

    typedef enum logic [1:0] {
        KIND_RUN  = 2'd0,
        KIND_HDR  = 2'd1,
        KIND_DATA = 2'd2
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  count;
        logic [7:0]  value;
    } token_t;

    // Access to the literal store: one write and one read port
    typedef struct packed {
        logic       wr_en;
        lit_idx_t   wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        lit_idx_t   rd_addr;
    } lit_cmd_t;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_MAIN      = 7'b0000010,
        ST_EOB       = 7'b0000100,
        ST_PUSH      = 7'b0001000,
        ST_FLUSH_HDR = 7'b0010000,
        ST_FLUSH_DAT = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

endpackage

[rtl/core/rlel_lit_buf.sv]
`timescale 1ns / 1ps

// Literal byte store: synchronous write, registered read, plus a copy of entry 0
module rlel_lit_buf
    import rlel_pkg::*;
(
    input  logic       clk,
    input  lit_cmd_t   cmd,
    output logic [7:0] rd_data,
    output logic [7:0] first_byte
);

    logic [7:0] mem [MAX_LITERAL];
    logic [7:0] rd_data_reg;
    logic [7:0] first_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    // Hold read data until the next read is issued
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // Keep entry 0 at hand for a group of one byte
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (cmd.wr_addr == '0))
        begin
            first_reg <= cmd.wr_data;
        end
    end

    assign rd_data    = rd_data_reg;
    assign first_byte = first_reg;

endmodule

[rtl/core/rle_encoder_with_literals.sv]
`timescale 1ns / 1ps

// Run-length encoder with literal groups.
// Input stream: one raw byte per word on s_axis_tdata, s_axis_tlast marks the last
// byte of a block and flushes everything pending. Output stream: one token per word,
// m_axis_tuser = kind (run, literal header, literal data), m_axis_tdata = count and
// byte, m_axis_tlast = last token caused by the input word just taken.
// Register max_run (written through max_run_wr_en / max_run_wr_data) sets the split
// length of long runs; values below 2 act as 2. Reset value 255. The user must see
// that max_run is written only while idle; the block itself does not enforce this.
// One input word is processed at a time by a small sequencer: accept, run check,
// optional end-of-block close, optional literal push, optional group flush, finish.
// A byte stored as a literal takes an extra push step. A group holds up to 32 bytes;
// each flush pass sends a group of 2 or more as a header and its bytes, read one per
// cycle from the literal store (registered read) while the receiver does not stall;
// a group of one leaves as a run of one. The end of a block always makes one pass.
// Tokens pass through a hold stage (so the last token of a word can be marked) and
// an output register; a stalled receiver freezes the sequencer at the next token,
// the input side keeps tready low until the word is fully done.
// Reset clears the run state, the literal count and the output valid; the literal
// store itself is not cleared, only entries written since the last flush are read.
module rle_encoder_with_literals
    import rlel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        max_run_wr_en,
    input  logic [7:0]  max_run_wr_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_block
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] token_count, [15:8] token_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
    output logic        m_axis_tlast    // last_of_burst
);

    state_t     state_reg, state_next;
    logic       eob_phase_reg, eob_phase_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_eob_reg, in_eob_next;
    logic [7:0] max_run_reg;

    // Run state
    logic [7:0] prev_reg, prev_next;
    logic       have_reg, have_next;
    logic [7:0] run_len_reg, run_len_next;

    // Literal state
    lit_len_t   lit_len_reg, lit_len_next;
    lit_idx_t   idx_reg, idx_next;
    logic [7:0] push_byte_reg, push_byte_next;
    lit_cmd_t   lit_cmd;
    logic [7:0] lit_rd_data;
    logic [7:0] lit_first;

    // Token hold stage and output register
    logic       hold_valid_reg, hold_valid_next;
    token_t     hold_reg, hold_next;
    logic       out_valid_reg, out_valid_next;
    token_t     out_reg, out_next;
    logic       out_last_reg, out_last_next;

    logic       slot_free;
    logic       emit_ok;
    logic       emit_req;
    token_t     emit_tok;
    logic [7:0] run_limit;
    logic       pending;
    logic       is_match;
    state_t     flush_done;

    rlel_lit_buf u_lit_buf (
        .clk        (clk),
        .cmd        (lit_cmd),
        .rd_data    (lit_rd_data),
        .first_byte (lit_first)
    );

    assign run_limit  = (max_run_reg < 8'd2) ? 8'd2 : max_run_reg;
    assign pending    = have_reg && (run_len_reg != 8'd0);
    assign is_match   = pending && (in_byte_reg == prev_reg);
    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign emit_ok    = !hold_valid_reg || slot_free;
    assign flush_done = eob_phase_reg ? ST_FINISH : ST_EOB;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        eob_phase_next  = eob_phase_reg;
        in_byte_next    = in_byte_reg;
        in_eob_next     = in_eob_reg;
        prev_next       = prev_reg;
        have_next       = have_reg;
        run_len_next    = run_len_reg;
        lit_len_next    = lit_len_reg;
        idx_next        = idx_reg;
        push_byte_next  = push_byte_reg;
        emit_req        = 1'b0;
        emit_tok        = '{kind: KIND_RUN, count: 8'd0, value: 8'd0};
        lit_cmd         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_byte_next   = s_axis_tdata;
                    in_eob_next    = s_axis_tlast;
                    eob_phase_next = 1'b0;
                    state_next     = ST_MAIN;
                end
            end

            ST_MAIN:
            begin
                if (is_match)
                begin
                    if (run_len_reg >= run_limit)
                    begin
                        // Split a run that reached the limit
                        emit_req = 1'b1;
                        emit_tok = '{kind: KIND_RUN, count: run_len_reg, value: in_byte_reg};
                        if (emit_ok)
                        begin
                            run_len_next = 8'd1;
                            state_next   = ST_EOB;
                        end
                    end
                    else
                    begin
                        run_len_next = run_len_reg + 8'd1;
                        // A run starts: close the literal group ahead of it
                        state_next   = (run_len_reg == 8'd1) ? ST_FLUSH_HDR : ST_EOB;
                    end
                end
                else if (pending && (run_len_reg >= 8'd2))
                begin
                    emit_req = 1'b1;
                    emit_tok = '{kind: KIND_RUN, count: run_len_reg, value: prev_reg};
                    if (emit_ok)
                    begin
                        prev_next    = in_byte_reg;
                        run_len_next = 8'd1;
                        have_next    = 1'b1;
                        state_next   = ST_EOB;
                    end
                end
                else if (pending)
                begin
                    push_byte_next = prev_reg;
                    prev_next      = in_byte_reg;
                    run_len_next   = 8'd1;
                    have_next      = 1'b1;
                    state_next     = ST_PUSH;
                end
                else
                begin
                    prev_next    = in_byte_reg;
                    run_len_next = 8'd1;
                    have_next    = 1'b1;
                    state_next   = ST_EOB;
                end
            end

            ST_EOB:
            begin
                if (!in_eob_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (pending && (run_len_reg >= 8'd2))
                begin
                    emit_req = 1'b1;
                    emit_tok = '{kind: KIND_RUN, count: run_len_reg, value: prev_reg};
                    if (emit_ok)
                    begin
                        eob_phase_next = 1'b1;
                        prev_next      = 8'd0;
                        have_next      = 1'b0;
                        run_len_next   = 8'd0;
                        state_next     = ST_FLUSH_HDR;
                    end
                end
                else
                begin
                    eob_phase_next = 1'b1;
                    push_byte_next = prev_reg;
                    prev_next      = 8'd0;
                    have_next      = 1'b0;
                    run_len_next   = 8'd0;
                    state_next     = pending ? ST_PUSH : ST_FLUSH_HDR;
                end
            end

            ST_PUSH:
            begin
                lit_cmd.wr_en   = 1'b1;
                lit_cmd.wr_addr = lit_len_reg[LIT_IDX_W-1:0];
                lit_cmd.wr_data = push_byte_reg;
                lit_len_next    = lit_len_reg + 1'b1;
                // Flush when the store fills up or the block ends
                if ((lit_len_reg == LIT_LEN_W'(MAX_LITERAL - 1)) || eob_phase_reg)
                begin
                    state_next = ST_FLUSH_HDR;
                end
                else
                begin
                    state_next = ST_EOB;
                end
            end

            ST_FLUSH_HDR:
            begin
                if (lit_len_reg == '0)
                begin
                    state_next = flush_done;
                end
                else if (lit_len_reg == LIT_LEN_W'(1))
                begin
                    // A lone single leaves as a run of one
                    emit_req = 1'b1;
                    emit_tok = '{kind: KIND_RUN, count: 8'd1, value: lit_first};
                    if (emit_ok)
                    begin
                        lit_len_next = '0;
                        state_next   = flush_done;
                    end
                end
                else
                begin
                    emit_req = 1'b1;
                    emit_tok = '{kind: KIND_HDR, count: 8'(lit_len_reg), value: 8'd0};
                    if (emit_ok)
                    begin
                        lit_cmd.rd_en   = 1'b1;
                        lit_cmd.rd_addr = '0;
                        idx_next        = '0;
                        state_next      = ST_FLUSH_DAT;
                    end
                end
            end

            ST_FLUSH_DAT:
            begin
                emit_req = 1'b1;
                emit_tok = '{kind: KIND_DATA, count: 8'd0, value: lit_rd_data};
                if (emit_ok)
                begin
                    if ((LIT_LEN_W'(idx_reg) + 1'b1) < lit_len_reg)
                    begin
                        // Fetch the next literal while this one leaves
                        lit_cmd.rd_en   = 1'b1;
                        lit_cmd.rd_addr = idx_reg + 1'b1;
                        idx_next        = idx_reg + 1'b1;
                    end
                    else
                    begin
                        lit_len_next = '0;
                        state_next   = flush_done;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!hold_valid_reg || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Token path: a new token pushes the held one out unmarked; finish marks the last
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        if (emit_req && emit_ok)
        begin
            hold_next       = emit_tok;
            hold_valid_next = 1'b1;
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
        end
        else if ((state_reg == ST_FINISH) && hold_valid_reg && slot_free)
        begin
            out_next        = hold_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            eob_phase_reg  <= 1'b0;
            max_run_reg    <= 8'd255;
            prev_reg       <= 8'd0;
            have_reg       <= 1'b0;
            run_len_reg    <= 8'd0;
            lit_len_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            eob_phase_reg  <= eob_phase_next;
            prev_reg       <= prev_next;
            have_reg       <= have_next;
            run_len_reg    <= run_len_next;
            lit_len_reg    <= lit_len_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (max_run_wr_en)
            begin
                max_run_reg <= max_run_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        in_eob_reg    <= in_eob_next;
        idx_reg       <= idx_next;
        push_byte_reg <= push_byte_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.value, out_reg.count};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;

endmodule
